[rtl/fcup_pkg.sv]
// ----------------------------------------------------------------------------
// fcup_pkg
// Shared types and constants for the framed command and upload parser.
// ----------------------------------------------------------------------------
package fcup_pkg;

	localparam int ECHO_DEPTH = 64;
	localparam int IDX_W      = (ECHO_DEPTH > 1) ? $clog2(ECHO_DEPTH) : 1;
	localparam int CNT_W      = $clog2(ECHO_DEPTH + 1);
	localparam int BATCH_W    = 7;
	localparam int MAX_BATCH  = 60;
	localparam int BATCH_CAP  = (MAX_BATCH < ECHO_DEPTH) ? MAX_BATCH : ECHO_DEPTH;

	localparam logic [7:0] SYNC_HEAD   = 8'h55;
	localparam logic [7:0] SYNC_SECOND = 8'h0A;
	localparam logic [7:0] SYNC_TAIL   = 8'hFF;
	localparam logic [7:0] LOCAL_HI    = 8'h07;
	localparam logic [7:0] REMOTE_LO   = 8'h20;
	localparam logic [7:0] REMOTE_HI   = 8'h28;
	localparam logic [7:0] CODE_UPLOAD = 8'h05;
	localparam logic [7:0] RESP_OFFSET = 8'h50;

	localparam logic [2:0] STEP_COUNT_BYTE = 3'd0;
	localparam logic [2:0] STEP_FIRST      = 3'd1;
	localparam logic [2:0] STEP_LAST       = 3'd5;

	typedef enum logic [2:0] {
		CFG_REGION1    = 3'd0,
		CFG_REGION2    = 3'd1,
		CFG_REGION3    = 3'd2,
		CFG_REGION4    = 3'd3,
		CFG_REGION5    = 3'd4,
		CFG_ECHO_BATCH = 3'd5
	} cfg_idx_t;

	typedef struct packed {
		logic take;
		logic mem_rd;
		logic echo_adv;
		logic echo_sel;
	} ctrl_cmd_t;

	typedef struct packed {
		logic flush_pend;
		logic echo_last;
	} dp_stat_t;

endpackage

[rtl/fcup_ctrl.sv]
// ----------------------------------------------------------------------------
// fcup_ctrl
// Sequencer: takes one byte and presents its step report; on a flush it then
// walks the echo buffer one transaction at a time.
// ----------------------------------------------------------------------------
module fcup_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	output logic                 out_valid,
	input  logic                 out_ready,
	input  fcup_pkg::dp_stat_t   stat,
	output fcup_pkg::ctrl_cmd_t  cmd
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_REPORT,
		ST_ECHO_RD,
		ST_ECHO_OUT
	} state_t;

	state_t state_q;
	logic   in_ready_q;
	logic   out_valid_q;

	assign in_ready  = in_ready_q;
	assign out_valid = out_valid_q;

	always_comb begin
		cmd          = '0;
		cmd.take     = in_ready_q & in_valid;
		cmd.mem_rd   = (state_q == ST_ECHO_RD);
		cmd.echo_sel = (state_q == ST_ECHO_OUT);
		cmd.echo_adv = (state_q == ST_ECHO_OUT) & out_ready;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			in_ready_q  <= 1'b1;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q     <= ST_REPORT;
						in_ready_q  <= 1'b0;
						out_valid_q <= 1'b1;
					end
				end
				ST_REPORT: begin
					if (out_ready) begin
						out_valid_q <= 1'b0;
						if (stat.flush_pend) begin
							state_q <= ST_ECHO_RD;
						end else begin
							state_q    <= ST_IDLE;
							in_ready_q <= 1'b1;
						end
					end
				end
				ST_ECHO_RD: begin
					state_q     <= ST_ECHO_OUT;
					out_valid_q <= 1'b1;
				end
				ST_ECHO_OUT: begin
					if (out_ready) begin
						out_valid_q <= 1'b0;
						if (stat.echo_last) begin
							state_q    <= ST_IDLE;
							in_ready_q <= 1'b1;
						end else begin
							state_q <= ST_ECHO_RD;
						end
					end
				end
				default: begin
					state_q     <= ST_IDLE;
					in_ready_q  <= 1'b1;
					out_valid_q <= 1'b0;
				end
			endcase
		end
	end

endmodule

[rtl/fcup_dp.sv]
// ----------------------------------------------------------------------------
// fcup_dp
// Datapath: frame window, upload tracking, echo buffer and result register.
// ----------------------------------------------------------------------------
module fcup_dp (
	input  logic                 clk,
	input  logic                 arst_n,
	input  fcup_pkg::ctrl_cmd_t  cmd,
	output fcup_pkg::dp_stat_t   stat,
	input  logic                 cfg_valid,
	input  logic [2:0]           cfg_index,
	input  logic [15:0]          cfg_data,
	input  logic [7:0]           rx_byte,
	output logic                 kind,
	output logic                 cmd_valid,
	output logic [7:0]           cmd_code,
	output logic                 response_valid,
	output logic [7:0]           response_code,
	output logic                 store_valid,
	output logic [2:0]           store_region,
	output logic [15:0]          store_offset,
	output logic                 upload_done,
	output logic [7:0]           echo_byte,
	output logic                 last
);

	logic [15:0] region_len_q [5];
	logic [5:0]  echo_batch_q;

	logic [7:0]  win_q [3];
	logic        upload_q;
	logic [2:0]  step_q;
	logic [15:0] offset_q;
	logic [fcup_pkg::CNT_W-1:0] echo_cnt_q;

	logic [7:0]  echo_mem [fcup_pkg::ECHO_DEPTH];
	logic [7:0]  rd_data_q;
	logic [fcup_pkg::CNT_W-1:0] rd_idx_q;
	logic [fcup_pkg::CNT_W-1:0] flush_n_q;
	logic        flush_q;

	logic        r_cmd_valid_q, r_resp_valid_q, r_store_valid_q, r_done_q;
	logic [7:0]  r_cmd_code_q, r_resp_code_q;
	logic [2:0]  r_region_q;
	logic [15:0] r_offset_q;

	// next-step values
	logic        n_cmd_valid, n_resp_valid, n_store_valid, n_done;
	logic [7:0]  n_cmd_code, n_resp_code;
	logic [2:0]  n_region, n_step;
	logic [15:0] n_offset, off_inc, cur_len;
	logic        n_upload, frame, known, n_flush, clear_cnt;
	logic [fcup_pkg::BATCH_W-1:0] cnt_inc, batch_lim;

	always_comb begin
		batch_lim = fcup_pkg::BATCH_W'(echo_batch_q);
		if (echo_batch_q == 6'd0)
			batch_lim = fcup_pkg::BATCH_W'(1);
		else if (batch_lim > fcup_pkg::BATCH_W'(fcup_pkg::BATCH_CAP))
			batch_lim = fcup_pkg::BATCH_W'(fcup_pkg::BATCH_CAP);
	end

	always_comb begin
		case (step_q)
			3'd1:    cur_len = region_len_q[0];
			3'd2:    cur_len = region_len_q[1];
			3'd3:    cur_len = region_len_q[2];
			3'd4:    cur_len = region_len_q[3];
			3'd5:    cur_len = region_len_q[4];
			default: cur_len = 16'd1;
		endcase
		if (cur_len == 16'd0)
			cur_len = 16'd1;
	end

	assign off_inc = offset_q + 16'd1;
	assign cnt_inc = fcup_pkg::BATCH_W'(echo_cnt_q) + fcup_pkg::BATCH_W'(1);
	assign frame   = (win_q[0] == fcup_pkg::SYNC_HEAD) && (win_q[1] == fcup_pkg::SYNC_SECOND)
		&& (rx_byte == fcup_pkg::SYNC_TAIL);
	assign known   = (win_q[2] <= fcup_pkg::LOCAL_HI)
		|| ((win_q[2] >= fcup_pkg::REMOTE_LO) && (win_q[2] <= fcup_pkg::REMOTE_HI));

	always_comb begin
		n_cmd_valid   = 1'b0;
		n_cmd_code    = 8'd0;
		n_resp_valid  = 1'b0;
		n_resp_code   = 8'd0;
		n_store_valid = 1'b0;
		n_region      = 3'd0;
		n_offset      = 16'd0;
		n_done        = 1'b0;
		n_flush       = 1'b0;
		n_upload      = upload_q;
		n_step        = step_q;
		clear_cnt     = 1'b0;
		if (!upload_q) begin
			if (frame && known) begin
				n_cmd_valid = 1'b1;
				n_cmd_code  = win_q[2];
				if (win_q[2] <= fcup_pkg::LOCAL_HI) begin
					n_resp_valid = 1'b1;
					n_resp_code  = win_q[2] + fcup_pkg::RESP_OFFSET;
				end
				if (win_q[2] == fcup_pkg::CODE_UPLOAD) begin
					n_upload  = 1'b1;
					n_step    = fcup_pkg::STEP_COUNT_BYTE;
					clear_cnt = 1'b1;
				end
			end
		end else begin
			n_flush = (cnt_inc >= batch_lim);
			if (step_q == fcup_pkg::STEP_COUNT_BYTE) begin
				n_store_valid = 1'b1;
				n_step        = fcup_pkg::STEP_FIRST;
			end else if (step_q <= fcup_pkg::STEP_LAST) begin
				n_store_valid = 1'b1;
				n_region      = step_q;
				n_offset      = offset_q;
				if (off_inc >= cur_len) begin
					if (step_q == fcup_pkg::STEP_LAST)
						n_done = 1'b1;
					else
						n_step = step_q + 3'd1;
				end
			end else begin
				n_done = 1'b1;
			end
			if (n_done) begin
				n_upload = 1'b0;
				n_step   = fcup_pkg::STEP_COUNT_BYTE;
				n_flush  = 1'b1;
			end
			clear_cnt = n_flush;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 5; i++)
				region_len_q[i] <= 16'd1;
			echo_batch_q <= 6'd60;
			for (int i = 0; i < 3; i++)
				win_q[i] <= 8'd0;
			upload_q   <= 1'b0;
			step_q     <= fcup_pkg::STEP_COUNT_BYTE;
			offset_q   <= 16'd0;
			echo_cnt_q <= '0;
			flush_q    <= 1'b0;
			flush_n_q  <= '0;
			rd_idx_q   <= '0;
		end else begin
			if (cfg_valid) begin
				case (fcup_pkg::cfg_idx_t'(cfg_index))
					fcup_pkg::CFG_REGION1:    region_len_q[0] <= cfg_data;
					fcup_pkg::CFG_REGION2:    region_len_q[1] <= cfg_data;
					fcup_pkg::CFG_REGION3:    region_len_q[2] <= cfg_data;
					fcup_pkg::CFG_REGION4:    region_len_q[3] <= cfg_data;
					fcup_pkg::CFG_REGION5:    region_len_q[4] <= cfg_data;
					fcup_pkg::CFG_ECHO_BATCH: echo_batch_q    <= cfg_data[5:0];
					default: ;
				endcase
			end
			if (cmd.take) begin
				flush_q   <= n_flush;
				flush_n_q <= fcup_pkg::CNT_W'(cnt_inc);
				rd_idx_q  <= '0;
				upload_q  <= n_upload;
				step_q    <= n_step;
				if (!upload_q) begin
					win_q[0] <= win_q[1];
					win_q[1] <= win_q[2];
					win_q[2] <= rx_byte;
					offset_q <= 16'd0;
				end else if (n_done || step_q == fcup_pkg::STEP_COUNT_BYTE
					|| off_inc >= cur_len) begin
					offset_q <= 16'd0;
				end else begin
					offset_q <= off_inc;
				end
				if (clear_cnt)
					echo_cnt_q <= '0;
				else if (upload_q)
					echo_cnt_q <= fcup_pkg::CNT_W'(cnt_inc);
			end else if (cmd.echo_adv) begin
				rd_idx_q <= rd_idx_q + fcup_pkg::CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			if (upload_q)
				echo_mem[echo_cnt_q[fcup_pkg::IDX_W-1:0]] <= rx_byte;
			r_cmd_valid_q   <= n_cmd_valid;
			r_cmd_code_q    <= n_cmd_code;
			r_resp_valid_q  <= n_resp_valid;
			r_resp_code_q   <= n_resp_code;
			r_store_valid_q <= n_store_valid;
			r_region_q      <= n_region;
			r_offset_q      <= n_offset;
			r_done_q        <= n_done;
		end
		if (cmd.mem_rd)
			rd_data_q <= echo_mem[rd_idx_q[fcup_pkg::IDX_W-1:0]];
	end

	assign stat.flush_pend = flush_q;
	assign stat.echo_last  = (rd_idx_q == flush_n_q - fcup_pkg::CNT_W'(1));

	assign kind           = cmd.echo_sel;
	assign cmd_valid      = cmd.echo_sel ? 1'b0  : r_cmd_valid_q;
	assign cmd_code       = cmd.echo_sel ? 8'd0  : r_cmd_code_q;
	assign response_valid = cmd.echo_sel ? 1'b0  : r_resp_valid_q;
	assign response_code  = cmd.echo_sel ? 8'd0  : r_resp_code_q;
	assign store_valid    = cmd.echo_sel ? 1'b0  : r_store_valid_q;
	assign store_region   = cmd.echo_sel ? 3'd0  : r_region_q;
	assign store_offset   = cmd.echo_sel ? 16'd0 : r_offset_q;
	assign upload_done    = cmd.echo_sel ? 1'b0  : r_done_q;
	assign echo_byte      = cmd.echo_sel ? rd_data_q : 8'd0;
	assign last           = cmd.echo_sel ? stat.echo_last : !flush_q;

endmodule

[rtl/framed_command_and_upload_parser.sv]
// ----------------------------------------------------------------------------
// framed_command_and_upload_parser
// Serial byte parser for command frames and table uploads.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready, rx_byte): one received byte per
// transaction. Output channel (out_valid/out_ready): each byte gives one step
// report (kind 0), then, on an echo flush, the buffered upload bytes in
// arrival order (kind 1); last marks the final result of a byte.
// Configuration channel (cfg_valid/cfg_ready, cfg_index, cfg_data): always
// ready; write only while the block is idle.
// Latency: the step report is valid in the cycle after the input transaction.
// Throughput: one byte at a time; on a flush, each echo byte is read from the
// echo buffer through a registered read (one read per echo byte) before it is
// presented on the output.
// Reset: command mode, empty frame window and echo buffer count, region
// lengths 1, echo batch 60. The echo buffer itself needs no clearing.
// Receiver stall: results hold on the output until taken; no new byte is
// accepted until the final result of the current byte has been taken.
// ----------------------------------------------------------------------------
module framed_command_and_upload_parser (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  rx_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        kind,
	output logic        cmd_valid,
	output logic [7:0]  cmd_code,
	output logic        response_valid,
	output logic [7:0]  response_code,
	output logic        store_valid,
	output logic [2:0]  store_region,
	output logic [15:0] store_offset,
	output logic        upload_done,
	output logic [7:0]  echo_byte,
	output logic        last,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	fcup_pkg::ctrl_cmd_t cmd;
	fcup_pkg::dp_stat_t  stat;

	assign cfg_ready = 1'b1;

	fcup_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	fcup_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.stat           (stat),
		.cfg_valid      (cfg_valid),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.rx_byte        (rx_byte),
		.kind           (kind),
		.cmd_valid      (cmd_valid),
		.cmd_code       (cmd_code),
		.response_valid (response_valid),
		.response_code  (response_code),
		.store_valid    (store_valid),
		.store_region   (store_region),
		.store_offset   (store_offset),
		.upload_done    (upload_done),
		.echo_byte      (echo_byte),
		.last           (last)
	);

endmodule

[rtl/fcup_chk.sv]
// ----------------------------------------------------------------------------
// fcup_chk
// Port checker for the framed command and upload parser.
// ----------------------------------------------------------------------------
module fcup_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic        kind,
	input logic        cmd_valid,
	input logic        response_valid,
	input logic        store_valid,
	input logic        upload_done,
	input logic [7:0]  echo_byte,
	input logic        last
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(kind) && $stable(last)
			&& $stable(echo_byte))
		else $error("result changed while stalled");

	a_report_first: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> out_valid && !kind && !in_ready)
		else $error("step report missing after input transaction");

	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && last |=> !out_valid && in_ready)
		else $error("result after last of a byte");

	a_echo_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind |-> !cmd_valid && !response_valid && !store_valid && !upload_done)
		else $error("echo result carries report fields");

endmodule

bind framed_command_and_upload_parser fcup_chk u_fcup_chk (.*);
